// File: hw/rtl/sfr_pkg.sv
// Package for the serial frame receiver: shared constants, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
package sfr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BASIC_START = 2'd0;
  localparam logic [1:0] REG_EXT_START   = 2'd1;
  localparam logic [1:0] REG_PATTERN_TYPE = 2'd2;
  localparam logic [1:0] REG_TIMEOUT     = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Result kinds
  localparam logic RES_BASIC   = 1'b0;
  localparam logic RES_PATTERN = 1'b1;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam int ROW_LIMIT = 16;

  // Controller to datapath
  typedef struct packed {
    logic accept;        // input channel open
    logic ld_basic_first;
    logic ld_ext_first;
    logic shift_basic;
    logic hdr_byte;
    logic pay_byte;
    logic tick;          // count one timeout tick
    logic clr_count;     // clear byte count and tick count
    logic out_basic;     // load basic packet into output register
    logic rd_lo;         // read address selects low byte of row
    logic latch_hi;
    logic out_row;       // load pattern row into output register
    logic row_clr;
    logic row_inc;
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_fire;
    logic is_tick;
    logic match_basic;
    logic match_ext;
    logic cnt_is4;
    logic len_over;
    logic len_zero;
    logic pay_last;
    logic check_ok;
    logic timeout_hit;
    logic slot_free;
    logic row_is_last;
  } sfr_stat_t;

endpackage

// File: hw/rtl/serial_frame_receiver_unit.sv
// Serial frame receiver, top level: joins the controller and the datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath (and through it sfr_ram).
//
// Usage:
//   Input channel (in_valid/in_stall): one request per received byte
//   (in_kind 0, in_rx_byte) or per time tick (in_kind 1). Bytes outside a
//   frame that match neither start code are dropped.
//   Result channel (out_valid/out_stall): a raw five-byte basic packet, or
//   one row per track of a valid pattern frame, the last row flagged.
//   Configuration: cfg_we with cfg_index/cfg_wdata writes one register
//   (basic start, extended start, pattern type, timeout ticks); write it
//   only while no frame is in progress and no result is pending.
// Timing:
//   An input request that causes no result leaves the input open, and the
//   next one is taken in the following cycle. The fifth basic byte closes
//   the input while the packet waits to move into the output register.
//   A good pattern checksum starts a row burst: each row steps through
//   ROW_HI, ROW_LO and ROW_OUT (two reads of the single-port payload store
//   plus output load), and the input stays closed until the last row loads.
//   While out_stall is high, the output register holds its result; input
//   is still taken until another result needs that register.
// Reset (rst_n low, synchronous): registers return to their defaults
//   (timeout 5 ticks, codes 0), the parser hunts, the output is empty.
//   The payload store needs no clearing pass.
module serial_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD   = 64,
  parameter int PATTERN_BYTES = 32,
  parameter int TRACK_COUNT   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [7:0]             in_rx_byte,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic [39:0]            out_basic_raw,
  output logic [7:0]             out_pattern_id,
  output logic [3:0]             out_track_index,
  output logic [15:0]            out_step_mask,
  output logic                   out_last_row,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  // the controller opens the input in every parsing state, closes it while
  // a result moves out
  assign in_stall = !cmd.accept;

  sfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .PATTERN_BYTES (PATTERN_BYTES),
    .TRACK_COUNT   (TRACK_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_basic_raw   (out_basic_raw),
    .out_pattern_id  (out_pattern_id),
    .out_track_index (out_track_index),
    .out_step_mask   (out_step_mask),
    .out_last_row    (out_last_row)
  );

endmodule

// File: hw/rtl/sfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/sfr_ctrl.sv
// Controller state machine of the serial frame receiver.
// Depends on sfr_pkg (command and status structs).
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sfr_stat_t stat,
  output sfr_cmd_t  cmd
);

  localparam logic [3:0] ST_HUNT    = 4'd0;
  localparam logic [3:0] ST_BASIC   = 4'd1;
  localparam logic [3:0] ST_HEADER  = 4'd2;
  localparam logic [3:0] ST_PAYLOAD = 4'd3;
  localparam logic [3:0] ST_CHECK   = 4'd4;
  localparam logic [3:0] ST_EMIT_B  = 4'd5;
  localparam logic [3:0] ST_ROW_HI  = 4'd6;
  localparam logic [3:0] ST_ROW_LO  = 4'd7;
  localparam logic [3:0] ST_ROW_OUT = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       byte_in;
  logic       tick_in;

  assign byte_in = stat.in_fire && !stat.is_tick;
  assign tick_in = stat.in_fire && stat.is_tick;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT: begin
        cmd.accept = 1'b1;
        if (byte_in && stat.match_basic) begin
          cmd.ld_basic_first = 1'b1;
          state_nxt = ST_BASIC;
        end else if (byte_in && stat.match_ext) begin
          cmd.ld_ext_first = 1'b1;
          state_nxt = ST_HEADER;
        end
      end
      ST_BASIC: begin
        cmd.accept = 1'b1;
        if (byte_in) begin
          cmd.shift_basic = 1'b1;
          if (stat.cnt_is4) begin
            cmd.clr_count = 1'b1;
            state_nxt = ST_EMIT_B;
          end
        end
      end
      ST_HEADER: begin
        cmd.accept = 1'b1;
        if (byte_in) begin
          cmd.hdr_byte = 1'b1;
          if (stat.cnt_is4) begin
            cmd.clr_count = 1'b1;
            if (stat.len_over) begin
              state_nxt = ST_HUNT;
            end else if (stat.len_zero) begin
              state_nxt = ST_CHECK;
            end else begin
              state_nxt = ST_PAYLOAD;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        cmd.accept = 1'b1;
        if (tick_in) begin
          cmd.tick = 1'b1;
          if (stat.timeout_hit) begin
            cmd.clr_count = 1'b1;
            state_nxt = ST_HUNT;
          end
        end else if (byte_in) begin
          cmd.pay_byte = 1'b1;
          if (stat.pay_last) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd.accept = 1'b1;
        if (tick_in) begin
          cmd.tick = 1'b1;
          if (stat.timeout_hit) begin
            cmd.clr_count = 1'b1;
            state_nxt = ST_HUNT;
          end
        end else if (byte_in) begin
          cmd.clr_count = 1'b1;
          if (stat.check_ok) begin
            cmd.row_clr = 1'b1;
            state_nxt = ST_ROW_HI;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_EMIT_B: begin
        if (stat.slot_free) begin
          cmd.out_basic = 1'b1;
          state_nxt = ST_HUNT;
        end
      end
      ST_ROW_HI: begin
        state_nxt = ST_ROW_LO;
      end
      ST_ROW_LO: begin
        cmd.rd_lo    = 1'b1;
        cmd.latch_hi = 1'b1;
        state_nxt = ST_ROW_OUT;
      end
      ST_ROW_OUT: begin
        // hold the low-byte address so the read data stays put while stalled
        cmd.rd_lo = 1'b1;
        if (stat.slot_free) begin
          cmd.out_row = 1'b1;
          if (stat.row_is_last) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.row_inc = 1'b1;
            state_nxt = ST_ROW_HI;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/sfr_datapath.sv
// Datapath of the serial frame receiver: configuration registers, frame
// counters, checksum, payload store and the output register.
// Depends on sfr_pkg and sfr_ram.
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD   = 64,
  parameter int PATTERN_BYTES = 32,
  parameter int TRACK_COUNT   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfr_cmd_t               cmd,
  output sfr_stat_t              stat,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_kind,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic [39:0]            out_basic_raw,
  output logic [7:0]             out_pattern_id,
  output logic [3:0]             out_track_index,
  output logic [15:0]            out_step_mask,
  output logic                   out_last_row
);

  localparam int CNT_LOG = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W   = (CNT_LOG > 3) ? CNT_LOG : 3;
  localparam int AW      = $clog2(PATTERN_BYTES);
  localparam int ROWS    = (TRACK_COUNT < ROW_LIMIT) ? TRACK_COUNT : ROW_LIMIT;

  // configuration
  logic [7:0]  basic_code_r, ext_code_r, pat_code_r;
  logic [15:0] timeout_r;

  // frame state
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       frame_type_r, frame_type_nxt;
  logic [7:0]       frame_id_r, frame_id_nxt;
  logic [15:0]      frame_len_r, frame_len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [39:0]      basic_r, basic_nxt;
  logic [15:0]      wait_r, wait_nxt, wait_inc;
  logic [3:0]       row_r, row_nxt;
  logic [7:0]       hi_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r;
  logic [39:0] out_raw_r;
  logic [7:0]  out_id_r;
  logic [3:0]  out_track_r;
  logic [15:0] out_mask_r;
  logic        out_last_r;

  logic          in_fire;
  logic [15:0]   len_full;
  logic [5:0]    row_byte;
  logic          row_has_data;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;

  assign in_fire  = in_valid && cmd.accept;
  assign len_full = {frame_len_r[15:8], in_rx_byte};
  assign wait_inc = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;

  assign stat.in_fire     = in_fire;
  assign stat.is_tick     = (in_kind == KIND_TICK);
  assign stat.match_basic = (in_rx_byte == basic_code_r);
  assign stat.match_ext   = (in_rx_byte == ext_code_r);
  assign stat.cnt_is4     = (byte_count_r == CNT_W'(4));
  assign stat.len_over    = (17'(len_full) > 17'(MAX_PAYLOAD));
  assign stat.len_zero    = (len_full == 16'd0);
  assign stat.pay_last    = ((17'(byte_count_r) + 17'd1) >= 17'(frame_len_r));
  assign stat.check_ok    = (in_rx_byte == sum_r) && (frame_type_r == pat_code_r) &&
                            (17'(frame_len_r) == 17'(PATTERN_BYTES));
  assign stat.timeout_hit = (wait_inc >= timeout_r);
  assign stat.slot_free   = !out_valid_r || !out_stall;
  assign stat.row_is_last = (row_r == 4'(ROWS - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basic_code_r <= 8'd0;
      ext_code_r   <= 8'd0;
      pat_code_r   <= 8'd0;
      timeout_r    <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASIC_START:  basic_code_r <= cfg_wdata[7:0];
        REG_EXT_START:    ext_code_r   <= cfg_wdata[7:0];
        REG_PATTERN_TYPE: pat_code_r   <= cfg_wdata[7:0];
        REG_TIMEOUT:      timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state update
  always_comb begin
    byte_count_nxt = byte_count_r;
    frame_type_nxt = frame_type_r;
    frame_id_nxt   = frame_id_r;
    frame_len_nxt  = frame_len_r;
    sum_nxt        = sum_r;
    basic_nxt      = basic_r;
    wait_nxt       = wait_r;

    if (cmd.ld_basic_first) begin
      basic_nxt = {32'd0, in_rx_byte};
    end
    if (cmd.shift_basic) begin
      basic_nxt = {basic_r[31:0], in_rx_byte};
    end
    if (cmd.ld_ext_first) begin
      sum_nxt = in_rx_byte;
    end
    if (cmd.hdr_byte || cmd.pay_byte) begin
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.hdr_byte) begin
      priority case (byte_count_r)
        CNT_W'(1): frame_type_nxt = in_rx_byte;
        CNT_W'(2): frame_id_nxt   = in_rx_byte;
        CNT_W'(3): frame_len_nxt  = {in_rx_byte, 8'd0};
        default:   frame_len_nxt  = len_full;
      endcase
    end
    if (cmd.tick) begin
      wait_nxt = wait_inc;
    end

    if (cmd.clr_count) begin
      byte_count_nxt = '0;
      wait_nxt       = 16'd0;
    end else if (cmd.ld_basic_first || cmd.ld_ext_first) begin
      byte_count_nxt = CNT_W'(1);
    end else if (cmd.shift_basic || cmd.hdr_byte || cmd.pay_byte) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      frame_type_r <= 8'd0;
      frame_id_r   <= 8'd0;
      frame_len_r  <= 16'd0;
      sum_r        <= 8'd0;
      basic_r      <= 40'd0;
      wait_r       <= 16'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
      frame_type_r <= frame_type_nxt;
      frame_id_r   <= frame_id_nxt;
      frame_len_r  <= frame_len_nxt;
      sum_r        <= sum_nxt;
      basic_r      <= basic_nxt;
      wait_r       <= wait_nxt;
    end
  end

  // payload store: bytes past the pattern size are summed, not stored
  assign ram_we = cmd.pay_byte && (17'(byte_count_r) < 17'(PATTERN_BYTES));

  assign row_byte     = {1'b0, row_r, cmd.rd_lo};
  assign ram_raddr    = AW'(row_byte);
  assign row_has_data = (7'({row_r, 1'b1}) < 7'(PATTERN_BYTES));

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(byte_count_r)),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    row_nxt = row_r;
    if (cmd.row_clr) begin
      row_nxt = 4'd0;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 4'd0;
    end else begin
      row_r <= row_nxt;
    end
    if (cmd.latch_hi) begin
      hi_r <= ram_rdata;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_basic || cmd.out_row) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_basic) begin
      out_kind_r  <= RES_BASIC;
      out_raw_r   <= basic_r;
      out_id_r    <= 8'd0;
      out_track_r <= 4'd0;
      out_mask_r  <= 16'd0;
      out_last_r  <= 1'b1;
    end else if (cmd.out_row) begin
      out_kind_r  <= RES_PATTERN;
      out_raw_r   <= 40'd0;
      out_id_r    <= frame_id_r;
      out_track_r <= row_r;
      out_mask_r  <= row_has_data ? {hi_r, ram_rdata} : 16'd0;
      out_last_r  <= stat.row_is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_basic_raw   = out_raw_r;
  assign out_pattern_id  = out_id_r;
  assign out_track_index = out_track_r;
  assign out_step_mask   = out_mask_r;
  assign out_last_row    = out_last_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_basic || cmd.out_row) |-> !(out_valid_r && out_stall))
    else $error("result loaded over a request still waiting");

  a_last_row_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == RES_PATTERN) |->
      (out_last_r == (out_track_r == 4'(ROWS - 1))))
    else $error("last row flag does not match track index");

  a_basic_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == RES_BASIC) |->
      (out_last_r && out_track_r == 4'd0 && out_mask_r == 16'd0 && out_id_r == 8'd0))
    else $error("basic result carries pattern fields");

  a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_row || cmd.latch_hi) |-> !cmd.accept)
    else $error("input accepted during pattern row output");
`endif

endmodule

// File: tb/sv/tb_serial_frame_receiver_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_frame_receiver_unit: directed and random request
// streams, a cycle-free frame parser predictor and an in-order result check.
// Depends on sfr_pkg and the serial_frame_receiver_unit RTL.
module tb_serial_frame_receiver_unit;
  import sfr_pkg::*;

  localparam int MAX_PAYLOAD    = 64;
  localparam int PATTERN_BYTES  = 32;
  localparam int TRACK_COUNT    = 16;
  localparam int ROW_COUNT      = (TRACK_COUNT < ROW_LIMIT) ? TRACK_COUNT : ROW_LIMIT;
  localparam int STORE_AW       = $clog2(PATTERN_BYTES);
  localparam int BASIC_BYTES    = 5;
  localparam int RANDOM_ITEMS   = 48;   // directed tests already send most requests
  localparam int RANDOM_PHASES  = 4;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000; // cycles without any transfer

  typedef enum logic [2:0] {
    PARSE_HUNT,
    PARSE_BASIC,
    PARSE_HEADER,
    PARSE_PAYLOAD,
    PARSE_CHECK
  } parse_phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [39:0] basic_raw;
    logic [7:0]  pattern_id;
    logic [3:0]  track_index;
    logic [15:0] step_mask;
    logic        last_row;
  } rx_result_t;

  // DUT ports; the inputs are all known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_kind = KIND_BYTE;
  logic [7:0]             in_rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_result_kind;
  logic [39:0]            out_basic_raw;
  logic [7:0]             out_pattern_id;
  logic [3:0]             out_track_index;
  logic [15:0]            out_step_mask;
  logic                   out_last_row;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies, reset values
  logic [7:0]  cfg_basic_code = 8'h00;
  logic [7:0]  cfg_ext_code = 8'h00;
  logic [7:0]  cfg_pattern_type = 8'h00;
  logic [15:0] cfg_timeout = 16'd5;

  // Parser state of the predictor, reset values
  parse_phase_t parse_phase = PARSE_HUNT;
  logic [6:0]   byte_count = '0;
  logic [7:0]   frame_type = '0;
  logic [7:0]   frame_id = '0;
  logic [15:0]  frame_length = '0;
  logic [7:0]   running_sum = '0;
  logic [39:0]  basic_shift = '0;
  logic [15:0]  wait_ticks = '0;
  logic [7:0]   payload_store [PATTERN_BYTES] = '{default: 8'h00};

  rx_result_t   rx_results_due [$];
  int unsigned  parsed_items = 0;   // requests the parser acted on
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 1;
  int unsigned  idle_cycles = 0;

  // Receiver stall control
  int unsigned  hold_requests = 0;
  int unsigned  holds_started = 0;
  int unsigned  hold_left = 0;
  int unsigned  mode_left = 0;
  int unsigned  stall_mode = 0;
  logic [7:0]   stall_pat = 8'h5A;

  serial_frame_receiver_unit #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .PATTERN_BYTES(PATTERN_BYTES),
    .TRACK_COUNT  (TRACK_COUNT)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_basic_raw  (out_basic_raw),
    .out_pattern_id (out_pattern_id),
    .out_track_index(out_track_index),
    .out_step_mask  (out_step_mask),
    .out_last_row   (out_last_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: advance the parser by one accepted request and queue the
  // results it causes.
  // ---------------------------------------------------------------------------
  function automatic void enter_hunt();
    parse_phase = PARSE_HUNT;
    byte_count  = '0;
    wait_ticks  = '0;
  endfunction

  task automatic parse_predict(input logic kind, input logic [7:0] rx);
    rx_result_t r;
    logic       good;
    if (kind == KIND_TICK) begin
      // Ticks only count while payload or checksum is outstanding
      if (parse_phase == PARSE_PAYLOAD || parse_phase == PARSE_CHECK) begin
        parsed_items++;
        if (wait_ticks != 16'hFFFF) wait_ticks++;
        if (wait_ticks >= cfg_timeout) enter_hunt();
      end
      return;
    end
    case (parse_phase)
      PARSE_HUNT: begin
        // Basic start code wins when both codes are equal
        if (rx == cfg_basic_code) begin
          basic_shift = {32'h0, rx};
          byte_count  = 7'd1;
          parse_phase = PARSE_BASIC;
          parsed_items++;
        end else if (rx == cfg_ext_code) begin
          running_sum = rx;
          byte_count  = 7'd1;
          parse_phase = PARSE_HEADER;
          parsed_items++;
        end
      end
      PARSE_BASIC: begin
        parsed_items++;
        basic_shift = {basic_shift[31:0], rx};
        byte_count++;
        if (byte_count >= BASIC_BYTES) begin
          r = '0;
          r.result_kind = RES_BASIC;
          r.basic_raw   = basic_shift;
          r.last_row    = 1'b1;
          rx_results_due.push_back(r);
          enter_hunt();
        end
      end
      PARSE_HEADER: begin
        parsed_items++;
        running_sum += rx;
        if (byte_count == 7'd4) begin
          frame_length[7:0] = rx;
          if (frame_length > MAX_PAYLOAD) begin
            enter_hunt();
          end else begin
            byte_count  = '0;
            wait_ticks  = '0;
            parse_phase = (frame_length == 0) ? PARSE_CHECK : PARSE_PAYLOAD;
          end
        end else begin
          if (byte_count == 7'd1) frame_type = rx;
          else if (byte_count == 7'd2) frame_id = rx;
          else frame_length = {rx, 8'h00};
          byte_count++;
        end
      end
      PARSE_PAYLOAD: begin
        parsed_items++;
        running_sum += rx;
        // Bytes past the pattern size are summed only
        if (byte_count < PATTERN_BYTES) payload_store[byte_count[STORE_AW-1:0]] = rx;
        byte_count++;
        if (byte_count >= frame_length) parse_phase = PARSE_CHECK;
      end
      PARSE_CHECK: begin
        parsed_items++;
        good = (rx == running_sum) && (frame_type == cfg_pattern_type) &&
               (frame_length == PATTERN_BYTES);
        enter_hunt();
        if (good) begin
          for (int t = 0; t < ROW_COUNT; t++) begin
            r = '0;
            r.result_kind = RES_PATTERN;
            r.pattern_id  = frame_id;
            r.track_index = t[3:0];
            if (2 * t + 1 < PATTERN_BYTES)
              r.step_mask = {payload_store[2 * t], payload_store[2 * t + 1]};
            r.last_row = (t == ROW_COUNT - 1);
            rx_results_due.push_back(r);
          end
        end
      end
      default: enter_hunt();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic kind, input logic [7:0] rx);
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= rx;
    // Hold the request until the block takes it
    do @(posedge clk); while (in_stall);
    parse_predict(kind, rx);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // End of burst: drop valid for a random gap, then pick the next burst
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic offer_tick(input int pct);
    if ($urandom_range(0, 99) < pct) send_request(KIND_TICK, 8'($urandom));
  endtask

  task automatic send_basic_packet(input logic [39:0] word, input int tick_pct);
    for (int i = BASIC_BYTES - 1; i >= 0; i--) begin
      if (i != BASIC_BYTES - 1) offer_tick(tick_pct);
      send_request(KIND_BYTE, word[i * 8 +: 8]);
    end
  endtask

  // Extended frame. fill_mode: 0 random, 1 zeros, 2 ones, 3 byte index.
  // cut_after >= 0 stops after that many payload bytes (no checksum sent).
  task automatic send_ext_frame(input logic [7:0] ftype, input logic [7:0] fid,
                                input logic [15:0] flen, input int fill_mode,
                                input bit bad_sum, input int tick_pct,
                                input int cut_after);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] hdr [4];
    hdr = '{ftype, fid, flen[15:8], flen[7:0]};
    sum = cfg_ext_code + ftype + fid + flen[15:8] + flen[7:0];
    send_request(KIND_BYTE, cfg_ext_code);
    foreach (hdr[i]) begin
      offer_tick(tick_pct);
      send_request(KIND_BYTE, hdr[i]);
    end
    if (flen > MAX_PAYLOAD) return;
    for (int i = 0; i < flen; i++) begin
      if (i == cut_after) return;
      case (fill_mode)
        0:       pb = 8'($urandom);
        1:       pb = 8'h00;
        2:       pb = 8'hFF;
        default: pb = i[7:0];
      endcase
      sum += pb;
      offer_tick(tick_pct);
      send_request(KIND_BYTE, pb);
    end
    if (cut_after == flen) return;
    offer_tick(tick_pct);
    send_request(KIND_BYTE, bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // Feed bytes until the parser hunts, then drain all results and let the
  // block settle so registers may be written.
  task automatic close_phase();
    while (parse_phase != PARSE_HUNT) send_request(KIND_BYTE, 8'($urandom));
    in_valid <= 1'b0;
    while (rx_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_BASIC_START:  cfg_basic_code   = value[7:0];
      REG_EXT_START:    cfg_ext_code     = value[7:0];
      REG_PATTERN_TYPE: cfg_pattern_type = value[7:0];
      REG_TIMEOUT:      cfg_timeout      = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Upper data bits of the byte registers carry junk that must be dropped
  task automatic load_registers(input logic [7:0] basic_code, input logic [7:0] ext_code,
                                input logic [7:0] ptype, input logic [15:0] timeout);
    write_register(REG_BASIC_START, {8'($urandom), basic_code});
    write_register(REG_EXT_START, {8'($urandom), ext_code});
    write_register(REG_PATTERN_TYPE, {8'($urandom), ptype});
    write_register(REG_TIMEOUT, timeout);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset registers: both start codes are zero, so zero opens a basic packet.
  task automatic test_default_registers();
    send_request(KIND_BYTE, 8'h80);    // dropped while hunting
    send_request(KIND_TICK, 8'hFF);    // tick while hunting is ignored
    send_basic_packet(40'h00_FF_01_80_7F, 0);
    close_phase();
  endtask

  task automatic test_basic_packets();
    load_registers(8'hA5, 8'h5A, 8'h01, 16'd3);
    send_request(KIND_BYTE, 8'h00);
    // Ticks inside a basic packet never time it out
    send_basic_packet(40'hA5_FF_FF_FF_FF, 0);
    send_request(KIND_BYTE, 8'hA5);
    repeat (6) send_request(KIND_TICK, 8'h00);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_BYTE, 8'h00);
    close_phase();
  endtask

  task automatic test_pattern_frames();
    send_ext_frame(8'h01, 8'hFF, 16'(PATTERN_BYTES), 3, 1'b0, 0, -1);
    send_ext_frame(8'h01, 8'h00, 16'd0, 0, 1'b0, 0, -1);        // zero length
    send_ext_frame(8'h01, 8'h12, 16'd1, 2, 1'b1, 0, -1);        // bad checksum
    send_ext_frame(8'h01, 8'h34, 16'(MAX_PAYLOAD + 1), 0, 1'b0, 0, -1);
    send_ext_frame(8'hFF, 8'h56, 16'hFFFF, 0, 1'b0, 0, -1);
    close_phase();
  endtask

  task automatic test_frame_timeouts();
    // Payload timeout after three ticks, then checksum-wait timeout
    send_ext_frame(8'h01, 8'h21, 16'(PATTERN_BYTES), 1, 1'b0, 0, 2);
    repeat (3) send_request(KIND_TICK, 8'h00);
    send_ext_frame(8'h01, 8'h22, 16'd2, 0, 1'b0, 0, 2);
    repeat (3) send_request(KIND_TICK, 8'h00);
    close_phase();
    // Zero timeout: the first tick abandons the frame
    write_register(REG_TIMEOUT, 16'd0);
    send_ext_frame(8'h01, 8'h23, 16'(PATTERN_BYTES), 0, 1'b0, 0, 1);
    send_request(KIND_TICK, 8'h00);
    close_phase();
  endtask

  task automatic test_extreme_registers();
    load_registers(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
    send_ext_frame(8'hFF, 8'h80, 16'(PATTERN_BYTES), 2, 1'b0, 25, -1);
    send_basic_packet(40'hFF_00_00_00_00, 25);
    send_ext_frame(8'hFF, 8'h81, 16'(MAX_PAYLOAD), 0, 1'b0, 0, -1);
    close_phase();
  endtask

  // Stop the receiver for a long stretch while requests keep coming, so the
  // row burst backs up into the input channel.
  task automatic test_output_backpressure();
    hold_requests++;
    repeat (3) send_ext_frame(cfg_pattern_type, 8'($urandom), 16'(PATTERN_BYTES),
                              0, 1'b0, 0, -1);
    send_basic_packet({cfg_basic_code, 32'($urandom)}, 0);
    close_phase();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    int          tick_pct;
    logic [7:0]  basic_code;
    logic [15:0] timeout;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      basic_code = 8'($urandom);
      case ($urandom_range(0, 5))
        0:       timeout = 16'd0;
        1:       timeout = 16'd1;
        2:       timeout = 16'($urandom_range(2, 8));
        3:       timeout = 16'hFFFF;
        default: timeout = 16'($urandom_range(3, 40));
      endcase
      load_registers(basic_code,
                     ($urandom_range(0, 9) == 0) ? basic_code : 8'($urandom),
                     8'($urandom), timeout);
      tick_pct = $urandom_range(0, 12);
      goal = parsed_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (parsed_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_ext_frame(cfg_pattern_type, 8'($urandom), 16'(PATTERN_BYTES), 0, 1'b0,
                         tick_pct, -1);
        end else if (pick < 55) begin
          send_basic_packet({cfg_basic_code, 32'($urandom)}, tick_pct);
        end else if (pick < 68) begin
          send_ext_frame(($urandom_range(0, 3) == 0) ? cfg_pattern_type : 8'($urandom),
                         8'($urandom), 16'($urandom_range(0, MAX_PAYLOAD)), 0,
                         $urandom_range(0, 3) == 0, tick_pct, -1);
        end else if (pick < 76) begin
          send_ext_frame(cfg_pattern_type, 8'($urandom), 16'(PATTERN_BYTES), 0, 1'b1,
                         tick_pct, -1);
        end else if (pick < 81) begin
          send_ext_frame(8'($urandom), 8'($urandom),
                         16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)), 0, 1'b0, 0, -1);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4))
            send_request(1'($urandom_range(0, 1)), 8'($urandom));
        end else begin
          // Broken frame left hanging, often followed by ticks
          send_ext_frame(cfg_pattern_type, 8'($urandom), 16'(PATTERN_BYTES), 0, 1'b0,
                         0, $urandom_range(0, PATTERN_BYTES));
          repeat ($urandom_range(0, 6)) send_request(KIND_TICK, 8'($urandom));
        end
      end
      close_phase();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rx_results_due.size() == 0) begin
        $error("result with nothing expected: kind %0d raw 0x%0h row %0d",
               out_result_kind, out_basic_raw, out_track_index);
        mismatch_count++;
      end else begin
        want = rx_results_due.pop_front();
        check_field("result_kind", 64'(want.result_kind), 64'(out_result_kind));
        check_field("basic_raw", 64'(want.basic_raw), 64'(out_basic_raw));
        check_field("pattern_id", 64'(want.pattern_id), 64'(out_pattern_id));
        check_field("track_index", 64'(want.track_index), 64'(out_track_index));
        check_field("step_mask", 64'(want.step_mask), 64'(out_step_mask));
        check_field("last_row", 64'(want.last_row), 64'(out_last_row));
      end
    end
  end

  // Receiver: a long hold on request, otherwise a pattern whose mode changes
  // at random (open, random, rotating mask).
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(16, 96);
        stall_mode = $urandom_range(0, 2);
        stall_pat  = 8'($urandom);
      end
      mode_left--;
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= stall_pat[0];
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Hold reset low, then release it at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_basic_packets();
    test_pattern_frames();
    test_frame_timeouts();
    test_extreme_registers();
    test_output_backpressure();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
